/* rtl/kmer_count_hash_table_assert.svh */
`ifndef KMER_COUNT_HASH_TABLE_ASSERT_SVH
`define KMER_COUNT_HASH_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KCHT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kcht check failed");

// next-cycle implication, sampled on clk, off during reset
`define KCHT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kcht check failed");

`endif

/* rtl/kcht_pkg.sv */
package kcht_pkg;

    localparam int KEY_W       = 64;
    localparam int OUT_COUNT_W = 32;
    localparam int TOTAL_W     = 13;

    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] key_count;
        logic                   is_new;
        logic                   table_full;
        logic [TOTAL_W-1:0]     entry_total;
    } res_t;

endpackage

/* rtl/kcht_req_if.sv */
interface kcht_req_if;

    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [kcht_pkg::KEY_W-1:0]  kmer_key;

    modport source (output valid, output req_type, output kmer_key, input ready);
    modport sink (input valid, input req_type, input kmer_key, output ready);

endinterface

/* rtl/kcht_rsp_if.sv */
interface kcht_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [kcht_pkg::OUT_COUNT_W-1:0]  key_count;
    logic                              is_new;
    logic                              table_full;
    logic [kcht_pkg::TOTAL_W-1:0]      entry_total;

    modport source (output valid, output key_count, output is_new, output table_full,
                    output entry_total, input ready);
    modport sink (input valid, input key_count, input is_new, input table_full,
                  input entry_total, output ready);

endinterface

/* rtl/kcht_ram.sv */
module kcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/kmer_count_hash_table.sv */
// channel | dir | beat contents
// req     | in  | req_type (0 count, 1 clear), kmer_key[63:0]
// rsp     | out | key_count[31:0], is_new, table_full, entry_total[12:0]
//
// A count request is accepted in ST_IDLE, then ST_PROBE reads one slot after another,
// each probe being one read of the key/valid RAM, along the linear probe chain.
// A clear request sweeps the key/valid RAM one slot a cycle, then waits for a free output.
// After reset the same sweep runs over all CAPACITY slots before the first request is taken.
// A full output register holds the final probe or sweep step until rsp is taken.
module kmer_count_hash_table #(
    parameter int CAPACITY   = 4096,
    parameter int COUNT_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    kcht_req_if.sink   req,
    kcht_rsp_if.source rsp
);

`include "kmer_count_hash_table_assert.svh"

    localparam int KW     = kcht_pkg::KEY_W;
    localparam int OW     = kcht_pkg::OUT_COUNT_W;
    localparam int TW     = kcht_pkg::TOTAL_W;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = (COUNT_BITS > OW) ? COUNT_BITS : OW;

    kcht_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0]  probe_reg, probe_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KW-1:0]     key_reg, key_next;
    logic              out_valid_reg;
    kcht_pkg::res_t    out_reg;

    logic [ADDR_W-1:0]     rd_addr;
    logic                  kwe;
    logic [ADDR_W-1:0]     kwaddr;
    logic [KW:0]           kwdata;
    logic [KW:0]           krdata;
    logic                  cwe;
    logic [COUNT_BITS-1:0] cwdata;
    logic [COUNT_BITS-1:0] crdata;

    logic                  load_out;
    kcht_pkg::res_t        res;
    logic                  out_free;
    logic [ADDR_W:0]       low_ext;
    logic [ADDR_W-1:0]     start_slot;
    logic [ADDR_W:0]       slot_inc;
    logic [ADDR_W-1:0]     next_slot;
    logic                  rd_valid;
    logic                  hit;
    logic                  last_probe;
    logic                  done;
    logic [COUNT_BITS-1:0] sat_cnt;
    logic [CW-1:0]         sat_wide;
    logic [OW-1:0]         sat_out;

    kcht_ram #(
        .WIDTH (KW + 1),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (kwe),
        .waddr (kwaddr),
        .wdata (kwdata),
        .raddr (rd_addr),
        .rdata (krdata)
    );

    kcht_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CAPACITY)
    ) u_count_ram (
        .clk   (clk),
        .we    (cwe),
        .waddr (slot_reg),
        .wdata (cwdata),
        .raddr (rd_addr),
        .rdata (crdata)
    );

    assign out_free   = !out_valid_reg || rsp.ready;
    assign low_ext    = {1'b0, req.kmer_key[ADDR_W-1:0]};
    assign start_slot = (low_ext >= (ADDR_W + 1)'(CAPACITY))
                        ? ADDR_W'(low_ext - (ADDR_W + 1)'(CAPACITY))
                        : low_ext[ADDR_W-1:0];
    assign slot_inc   = {1'b0, slot_reg} + (ADDR_W + 1)'(1);
    assign next_slot  = (slot_inc == (ADDR_W + 1)'(CAPACITY)) ? '0 : slot_inc[ADDR_W-1:0];
    assign rd_valid   = krdata[KW];
    assign hit        = rd_valid && (krdata[KW-1:0] == key_reg);
    assign last_probe = (probe_reg == CNT_W'(CAPACITY - 1));
    assign done       = !rd_valid || hit || last_probe;
    assign sat_cnt    = (crdata == '1) ? crdata : crdata + COUNT_BITS'(1);
    assign sat_wide   = CW'(sat_cnt);
    assign sat_out    = (sat_wide > CW'({OW{1'b1}})) ? '1 : sat_wide[OW-1:0];

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        sweep_next = sweep_reg;
        probe_next = probe_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        req.ready  = 1'b0;
        rd_addr    = slot_reg;
        kwe        = 1'b0;
        kwaddr     = slot_reg;
        kwdata     = {1'b1, key_reg};
        cwe        = 1'b0;
        cwdata     = COUNT_BITS'(1);
        load_out   = 1'b0;
        res        = '0;

        case (state_reg)
            kcht_pkg::ST_INIT:
            begin
                kwe    = 1'b1;
                kwaddr = sweep_reg;
                kwdata = '0;
                if (sweep_reg == ADDR_W'(CAPACITY - 1))
                begin
                    sweep_next = '0;
                    state_next = kcht_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            kcht_pkg::ST_CLEAR:
            begin
                kwe    = 1'b1;
                kwaddr = sweep_reg;
                kwdata = '0;
                if (sweep_reg != ADDR_W'(CAPACITY - 1))
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    sweep_next = '0;
                    state_next = kcht_pkg::ST_IDLE;
                end
            end
            kcht_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                rd_addr   = start_slot;
                if (req.valid)
                begin
                    if (req.req_type == kcht_pkg::REQ_CLEAR)
                    begin
                        cnt_next   = '0;
                        state_next = kcht_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        key_next   = req.kmer_key;
                        slot_next  = start_slot;
                        probe_next = '0;
                        state_next = kcht_pkg::ST_PROBE;
                    end
                end
            end
            kcht_pkg::ST_PROBE:
            begin
                if (!done)
                begin
                    rd_addr    = next_slot;
                    slot_next  = next_slot;
                    probe_next = probe_reg + CNT_W'(1);
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = kcht_pkg::ST_IDLE;
                    if (hit)
                    begin
                        cwe               = 1'b1;
                        cwdata            = sat_cnt;
                        res.key_count     = sat_out;
                        res.entry_total   = TW'(cnt_reg);
                    end
                    else if (!rd_valid && (cnt_reg < CNT_W'(CAPACITY)))
                    begin
                        kwe               = 1'b1;
                        cwe               = 1'b1;
                        cnt_next          = cnt_reg + CNT_W'(1);
                        res.key_count     = OW'(1);
                        res.is_new        = 1'b1;
                        res.entry_total   = TW'(cnt_reg + CNT_W'(1));
                    end
                    else
                    begin
                        res.table_full    = 1'b1;
                        res.entry_total   = TW'(cnt_reg);
                    end
                end
            end
            default:
            begin
                state_next = kcht_pkg::ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kcht_pkg::ST_INIT;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        probe_reg <= probe_next;
        key_reg   <= key_next;
        if (load_out)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.key_count   = out_reg.key_count;
    assign rsp.is_new      = out_reg.is_new;
    assign rsp.table_full  = out_reg.table_full;
    assign rsp.entry_total = out_reg.entry_total;

    `KCHT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(CAPACITY))
    `KCHT_ASSERT_NEXT(a_insert_grows, load_out && res.is_new, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `KCHT_ASSERT_NOW(a_probe_write, (state_reg == kcht_pkg::ST_PROBE) && (kwe || cwe), load_out)
    `KCHT_ASSERT_NOW(a_accept_idle, req.valid && req.ready, state_reg == kcht_pkg::ST_IDLE)

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             SLOTS       = 4096;
    localparam int             N_RANDOM    = 1600;
    localparam int             IDLE_PCT    = 18;
    localparam int             TAIL_CYCLES = 50;
    localparam int unsigned    CYCLE_LIMIT = 2_000_000;
    localparam kcht_pkg::res_t NO_RES      = '0;

    typedef struct {
        logic                       req_type;
        logic [kcht_pkg::KEY_W-1:0] key;
        bit                         fixed;
        kcht_pkg::res_t             want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    bit          calm;
    int unsigned cycle_cnt;
    int          mismatch_cnt;
    int          checked_cnt;
    int          refused_cnt;
    int          clear_cnt;
    int          peak_total;

    kcht_pkg::res_t tally_q [$];

    logic [kcht_pkg::KEY_W-1:0]       slot_key   [SLOTS];
    logic [kcht_pkg::OUT_COUNT_W-1:0] slot_count [SLOTS];
    bit                               slot_used  [SLOTS];
    int                               held_total;
    logic [kcht_pkg::KEY_W-1:0]       recent_keys [$];

    kcht_req_if req_bus ();
    kcht_rsp_if rsp_bus ();

    kmer_count_hash_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    always @(posedge clk) rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    function automatic kcht_pkg::res_t predict_tally(input logic req_type,
                                                     input logic [kcht_pkg::KEY_W-1:0] key);
        kcht_pkg::res_t r;
        int             slot;
        int             probes;
        r = '0;
        if (req_type == kcht_pkg::REQ_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            held_total = 0;
        end
        else
        begin
            slot   = int'(key % SLOTS);
            probes = 0;
            while (probes < SLOTS && slot_used[slot] && slot_key[slot] != key)
            begin
                slot = (slot + 1) % SLOTS;
                probes++;
            end
            if (probes < SLOTS && slot_used[slot])
            begin
                if (slot_count[slot] != '1)
                    slot_count[slot]++;
                r.key_count = slot_count[slot];
            end
            else if (probes < SLOTS && held_total < SLOTS)
            begin
                slot_used[slot]  = 1'b1;
                slot_key[slot]   = key;
                slot_count[slot] = kcht_pkg::OUT_COUNT_W'(1);
                held_total++;
                r.key_count = kcht_pkg::OUT_COUNT_W'(1);
                r.is_new    = 1'b1;
            end
            else
                r.table_full = 1'b1;
        end
        r.entry_total = kcht_pkg::TOTAL_W'(held_total);
        return r;
    endfunction

    task automatic push_beat(input logic req_type, input logic [kcht_pkg::KEY_W-1:0] key,
                             input bit fixed, input kcht_pkg::res_t want);
        int             gaps;
        kcht_pkg::res_t predicted;
        gaps = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT)
            gaps++;
        if (gaps > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= req_type;
        req_bus.kmer_key <= key;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        predicted = predict_tally(req_type, key);
        if (req_type == kcht_pkg::REQ_CLEAR)
            clear_cnt++;
        if (held_total > peak_total)
            peak_total = held_total;
        if (predicted.is_new)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 256)
                void'(recent_keys.pop_front());
        end
        tally_q.push_back(fixed ? want : predicted);
    endtask

    // hold the sender until every response is back
    task automatic drain_hold;
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (tally_q.size() != 0);
    endtask

    always @(posedge clk)
    begin
        kcht_pkg::res_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (tally_q.size() == 0)
            begin
                $display("%0t: unexpected beat: count %0d new %0b full %0b total %0d", $time,
                         rsp_bus.key_count, rsp_bus.is_new, rsp_bus.table_full,
                         rsp_bus.entry_total);
                mismatch_cnt++;
            end
            else
            begin
                want = tally_q.pop_front();
                checked_cnt++;
                if (rsp_bus.table_full === 1'b1)
                    refused_cnt++;
                if (rsp_bus.key_count !== want.key_count)
                begin
                    $display("%0t: key_count expected %0d actual %0d", $time,
                             want.key_count, rsp_bus.key_count);
                    mismatch_cnt++;
                end
                if (rsp_bus.is_new !== want.is_new)
                begin
                    $display("%0t: is_new expected %0b actual %0b", $time,
                             want.is_new, rsp_bus.is_new);
                    mismatch_cnt++;
                end
                if (rsp_bus.table_full !== want.table_full)
                begin
                    $display("%0t: table_full expected %0b actual %0b", $time,
                             want.table_full, rsp_bus.table_full);
                    mismatch_cnt++;
                end
                if (rsp_bus.entry_total !== want.entry_total)
                begin
                    $display("%0t: entry_total expected %0d actual %0d", $time,
                             want.entry_total, rsp_bus.entry_total);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb_top: timeout after %0d cycles, %0d responses pending", cycle_cnt,
                 tally_q.size());
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        plan_row_t                  plan [16];
        logic [kcht_pkg::KEY_W-1:0] key;
        int                         pick;

        plan = '{
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_0000, 1'b1,
              '{32'd1, 1'b1, 1'b0, 13'd1}},
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_0000, 1'b1,
              '{32'd2, 1'b0, 1'b0, 13'd1}},
            '{kcht_pkg::REQ_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{32'd1, 1'b1, 1'b0, 13'd2}},
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_1000, 1'b1,
              '{32'd1, 1'b1, 1'b0, 13'd3}},
            '{kcht_pkg::REQ_COUNT, 64'hFFFF_FFFF_FFFF_F000, 1'b1,
              '{32'd1, 1'b1, 1'b0, 13'd4}},
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_1000, 1'b1,
              '{32'd2, 1'b0, 1'b0, 13'd4}},
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_0FFF, 1'b0, NO_RES},
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_1FFF, 1'b0, NO_RES},
            '{kcht_pkg::REQ_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RES},
            '{kcht_pkg::REQ_COUNT, 64'h5555_5555_5555_5555, 1'b0, NO_RES},
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_1FFF, 1'b0, NO_RES},
            '{kcht_pkg::REQ_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, NO_RES},
            '{kcht_pkg::REQ_CLEAR, 64'h0000_0000_0000_0000, 1'b1, NO_RES},
            '{kcht_pkg::REQ_COUNT, 64'h0000_0000_0000_0000, 1'b1,
              '{32'd1, 1'b1, 1'b0, 13'd1}},
            '{kcht_pkg::REQ_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{32'd1, 1'b1, 1'b0, 13'd2}},
            '{kcht_pkg::REQ_CLEAR, 64'h5555_5555_5555_5555, 1'b1, NO_RES}
        };

        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= kcht_pkg::REQ_COUNT;
        req_bus.kmer_key <= '0;
        calm       = 1'b0;
        held_total = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            push_beat(plan[i].req_type, plan[i].key, plan[i].fixed, plan[i].want);
        drain_hold();

        // fill every slot, then hit present and absent keys on the full store
        calm = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            key       = {$urandom, $urandom};
            key[11:0] = 12'(i);
            push_beat(kcht_pkg::REQ_COUNT, key, 1'b0, NO_RES);
        end
        for (int i = 0; i < 8; i++)
            push_beat(kcht_pkg::REQ_COUNT,
                      recent_keys[$urandom_range(recent_keys.size() - 1)], 1'b0, NO_RES);
        for (int i = 0; i < 3; i++)
        begin
            key = {$urandom, $urandom};
            push_beat(kcht_pkg::REQ_COUNT, key, 1'b1,
                      '{32'd0, 1'b0, 1'b1, kcht_pkg::TOTAL_W'(SLOTS)});
        end
        push_beat(kcht_pkg::REQ_CLEAR, key, 1'b1, NO_RES);
        calm = 1'b0;

        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 600 && n < 900);
            pick = $urandom_range(999);
            if (pick < 8)
                push_beat(kcht_pkg::REQ_CLEAR, {$urandom, $urandom}, 1'b0, NO_RES);
            else
            begin
                key = {$urandom, $urandom};
                if (pick < 520 && recent_keys.size() != 0)
                    key = recent_keys[$urandom_range(recent_keys.size() - 1)];
                else if (pick < 720 && recent_keys.size() != 0)
                    key[11:0] = recent_keys[$urandom_range(recent_keys.size() - 1)][11:0];
                else if (pick < 800)
                    key = {{52{pick[0]}}, 12'($urandom_range(47))};
                push_beat(kcht_pkg::REQ_COUNT, key, 1'b0, NO_RES);
            end
            if ($urandom_range(99) == 0)
                drain_hold();
        end
        calm = 1'b0;

        req_bus.valid <= 1'b0;
        while (tally_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d responses checked, %0d clears, %0d refused inserts",
                 checked_cnt, clear_cnt, refused_cnt);
        $display("tb_top: store filled to %0d of %0d entries, with probe chains and wrap",
                 peak_total, SLOTS);
        if (mismatch_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
